[hw/rtl/infix_to_postfix_converter_macros.svh]
// Assertion macros used by the checker file of the converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/itp_pkg.sv]
// Types, character codes and precedence helpers of the infix to postfix converter.
`default_nettype none

package itp_pkg;

	localparam int DEFAULT_STACK_DEPTH = 32;
	localparam int DEFAULT_QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;

	localparam logic [2:0] PREC_OPEN = 3'd1;
	localparam logic [2:0] PREC_ADD  = 3'd2;
	localparam logic [2:0] PREC_MUL  = 3'd4;
	localparam logic [2:0] PREC_POW  = 3'd6;

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       has_symbol;
		logic       end_of_expression;
		logic       error;
	} out_word_t;

	typedef enum logic [2:0] {
		KIND_SKIP,
		KIND_OPEN,
		KIND_CLOSE,
		KIND_OPER,
		KIND_OPND
	} sym_kind_t;

	typedef struct packed {
		logic [7:0] sym;
		sym_kind_t  kind;
		logic [2:0] prec;
		logic       last;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_MAIN,
		ST_FLUSH,
		ST_END
	} back_state_t;

	function automatic logic [2:0] prec_of(input logic [7:0] sym);
		logic [2:0] p;
		p = PREC_OPEN;
		if (sym inside {CH_PLUS, CH_MINUS}) begin
			p = PREC_ADD;
		end else if (sym inside {CH_STAR, CH_SLASH}) begin
			p = PREC_MUL;
		end else if (sym inside {CH_CARET, CH_DOLLAR}) begin
			p = PREC_POW;
		end
		return p;
	endfunction

	function automatic logic is_operator(input logic [7:0] sym);
		return sym inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_DOLLAR};
	endfunction

endpackage

`default_nettype wire

[hw/rtl/itp_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/itp_front.sv]
// Front end: takes input words and classifies each character into a command.
`default_nettype none

module itp_front
	import itp_pkg::*;
(
	input  wire logic     sym_valid,
	output logic          sym_ready,
	input  wire in_word_t sym_word,
	output logic          cmd_valid,
	input  wire logic     cmd_ready,
	output cmd_t          cmd
);

	assign sym_ready = cmd_ready;
	assign cmd_valid = sym_valid;

	always_comb begin
		cmd.sym  = sym_word.symbol;
		cmd.last = sym_word.is_last;
		cmd.prec = prec_of(sym_word.symbol);
		if (sym_word.symbol == CH_SPACE) begin
			cmd.kind = KIND_SKIP;
		end else if (sym_word.symbol == CH_OPEN) begin
			cmd.kind = KIND_OPEN;
		end else if (sym_word.symbol == CH_CLOSE) begin
			cmd.kind = KIND_CLOSE;
		end else if (is_operator(sym_word.symbol)) begin
			cmd.kind = KIND_OPER;
		end else begin
			cmd.kind = KIND_OPND;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/itp_cmd_queue.sv]
// Short command queue between the front end and the stack engine.
`default_nettype none

module itp_cmd_queue
	import itp_pkg::*;
#(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      head_valid,
	output cmd_t      head_cmd,
	input  wire logic pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != CW'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/itp_back.sv]
// Stack engine: runs commands against the operator stack and drives the output register.
`default_nettype none

module itp_back
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      post_valid,
	input  wire logic post_ready,
	output out_word_t post_word
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	back_state_t   state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]    top_q, top_d;
	logic          rd_fresh_q;
	logic          err_q, err_d;
	logic          hold_valid_q, hold_valid_d;
	logic [7:0]    hold_sym_q, hold_sym_d;
	logic          out_valid_q, out_valid_d;
	out_word_t     out_q, out_d;

	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;

	logic          out_free;
	logic          empty;
	logic          full;
	logic          below_ok;
	logic          do_emit;
	logic [7:0]    emit_sym;
	logic          do_pop;
	logic          do_push;
	logic          main_done;
	logic          set_err;
	logic          finish;

	// The top of stack lives in top_q; the RAM holds the entries below it.
	assign waddr = count_q[AW-1:0] - AW'(1);
	assign raddr = count_q[AW-1:0] - AW'(2);

	itp_ram #(
		.WIDTH(8),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(top_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_free   = !out_valid_q || post_ready;
	assign empty      = (count_q == '0);
	assign full       = (count_q == CW'(STACK_DEPTH));
	assign below_ok   = (count_q == CW'(1)) || rd_fresh_q;
	assign post_valid = out_valid_q;
	assign post_word  = out_q;

	always_comb begin
		do_emit   = 1'b0;
		emit_sym  = top_q;
		do_pop    = 1'b0;
		do_push   = 1'b0;
		main_done = 1'b0;
		set_err   = 1'b0;
		finish    = 1'b0;
		cmd_pop   = 1'b0;
		state_d   = state_q;

		case (state_q)
			ST_MAIN: begin
				if (cmd_valid) begin
					case (cmd.kind)
						KIND_SKIP: begin
							main_done = 1'b1;
						end
						KIND_OPND: begin
							if (out_free) begin
								do_emit   = 1'b1;
								emit_sym  = cmd.sym;
								main_done = 1'b1;
							end
						end
						KIND_OPEN: begin
							do_push   = 1'b1;
							main_done = 1'b1;
						end
						KIND_CLOSE: begin
							if (empty) begin
								set_err   = 1'b1;
								main_done = 1'b1;
							end else if (top_q == CH_OPEN) begin
								if (below_ok) begin
									do_pop    = 1'b1;
									main_done = 1'b1;
								end
							end else if (below_ok && out_free) begin
								do_emit = 1'b1;
								do_pop  = 1'b1;
							end
						end
						KIND_OPER: begin
							if (!empty && (prec_of(top_q) >= cmd.prec)) begin
								if (below_ok && out_free) begin
									do_emit = 1'b1;
									do_pop  = 1'b1;
								end
							end else begin
								do_push   = 1'b1;
								main_done = 1'b1;
							end
						end
						default: begin
							main_done = 1'b1;
						end
					endcase
					if (main_done) begin
						if (cmd.last) begin
							state_d = ST_FLUSH;
						end else begin
							cmd_pop = 1'b1;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (empty) begin
					state_d = ST_END;
				end else if (below_ok) begin
					if (top_q == CH_OPEN) begin
						do_pop  = 1'b1;
						set_err = 1'b1;
					end else if (out_free) begin
						do_emit = 1'b1;
						do_pop  = 1'b1;
					end
				end
			end
			ST_END: begin
				if (out_free) begin
					finish  = 1'b1;
					cmd_pop = 1'b1;
					state_d = ST_MAIN;
				end
			end
			default: begin
				state_d = ST_MAIN;
			end
		endcase
	end

	always_comb begin
		count_d      = count_q;
		top_d        = top_q;
		we           = 1'b0;
		err_d        = err_q || set_err;
		hold_valid_d = hold_valid_q;
		hold_sym_d   = hold_sym_q;
		out_valid_d  = out_valid_q && !post_ready;
		out_d        = out_q;

		if (do_pop) begin
			count_d = count_q - CW'(1);
			top_d   = rdata;
		end

		if (do_push) begin
			if (full) begin
				err_d = 1'b1;
			end else begin
				we      = !empty;
				count_d = count_q + CW'(1);
				top_d   = cmd.sym;
			end
		end

		// During the final character each result waits one step in the hold
		// register, so the end mark can go on whichever result turns out last.
		if (do_emit) begin
			if (cmd.last) begin
				if (hold_valid_q) begin
					out_valid_d             = 1'b1;
					out_d.out_symbol        = hold_sym_q;
					out_d.has_symbol        = 1'b1;
					out_d.end_of_expression = 1'b0;
					out_d.error             = 1'b0;
				end
				hold_valid_d = 1'b1;
				hold_sym_d   = emit_sym;
			end else begin
				out_valid_d             = 1'b1;
				out_d.out_symbol        = emit_sym;
				out_d.has_symbol        = 1'b1;
				out_d.end_of_expression = 1'b0;
				out_d.error             = 1'b0;
			end
		end

		if (finish) begin
			out_valid_d             = 1'b1;
			out_d.out_symbol        = hold_valid_q ? hold_sym_q : 8'h00;
			out_d.has_symbol        = hold_valid_q;
			out_d.end_of_expression = 1'b1;
			out_d.error             = err_q;
			hold_valid_d            = 1'b0;
			err_d                   = 1'b0;
			count_d                 = '0;
		end
	end

	always_ff @(posedge clk) begin
		top_q      <= top_d;
		hold_sym_q <= hold_sym_d;
		out_q      <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_MAIN;
			count_q      <= '0;
			rd_fresh_q   <= 1'b0;
			err_q        <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			rd_fresh_q   <= (count_d == count_q);
			err_q        <= err_d;
			hold_valid_q <= hold_valid_d;
			out_valid_q  <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/infix_to_postfix_converter.sv]
// An operand is registered in the command queue and then in the output register before it
// appears on post_word. A stack pop may wait for the registered read port of the stack RAM;
// once the stack of the final character is empty, the engine moves to its end state and
// from there sends the end word. A queue of QUEUE_DEPTH commands lets input words
// arrive while pops run. Reset (arst_n low, asynchronous) empties the stack, queue and
// output register and clears the error flag; RAM contents are kept.
`default_nettype none

module infix_to_postfix_converter
	import itp_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     sym_valid,
	output logic          sym_ready,
	input  wire in_word_t sym_word,
	output logic          post_valid,
	input  wire logic     post_ready,
	output out_word_t     post_word
);

	// Front end to queue: each accepted word becomes one classified command.
	logic cls_valid;
	logic cls_ready;
	cmd_t cls_cmd;

	// Queue to stack engine: the head command stays in place until the
	// engine has finished all of its work, including the final flush.
	logic head_valid;
	cmd_t head_cmd;
	logic head_pop;

	// The front end tags each character as space, open or close parenthesis,
	// operator (with its precedence) or operand.
	itp_front u_front (
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.sym_word (sym_word),
		.cmd_valid(cls_valid),
		.cmd_ready(cls_ready),
		.cmd      (cls_cmd)
	);

	itp_cmd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(cls_valid),
		.push_ready(cls_ready),
		.push_cmd  (cls_cmd),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (head_pop)
	);

	// The stack engine keeps the top operator in a register and the rest in
	// RAM. It pops while precedence allows, pushes, and on the final character
	// flushes the stack and sends the word that carries the end mark and error.
	itp_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (head_pop),
		.post_valid(post_valid),
		.post_ready(post_ready),
		.post_word (post_word)
	);

endmodule

`default_nettype wire

[hw/rtl/itp_checker.sv]
// Port-level checker for the infix to postfix converter, with its bind.
`default_nettype none

`include "infix_to_postfix_converter_macros.svh"

module itp_checker
	import itp_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      sym_valid,
	input wire logic      sym_ready,
	input wire in_word_t  sym_word,
	input wire logic      post_valid,
	input wire logic      post_ready,
	input wire out_word_t post_word
);

	// Count of final characters taken in whose end word is still owed.
	logic [3:0] lasts_q;
	logic       last_in;
	logic       end_out;

	assign last_in = sym_valid && sym_ready && sym_word.is_last;
	assign end_out = post_valid && post_ready && post_word.end_of_expression;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lasts_q <= '0;
		end else if (last_in && !end_out) begin
			lasts_q <= lasts_q + 4'd1;
		end else if (end_out && !last_in) begin
			lasts_q <= lasts_q - 4'd1;
		end
	end

	`ITP_ASSERT_NEXT(a_post_hold, clk, arst_n, post_valid && !post_ready, post_valid && $stable(post_word), "output word changed while stalled")
	`ITP_ASSERT_SAME(a_bare_marker, clk, arst_n, post_valid && !post_word.has_symbol, post_word.end_of_expression && (post_word.out_symbol == 8'h00), "bare word without end mark")
	`ITP_ASSERT_SAME(a_error_at_end, clk, arst_n, post_valid && post_word.error, post_word.end_of_expression, "error reported away from end")
	`ITP_ASSERT_SAME(a_end_owed, clk, arst_n, end_out, lasts_q != 4'd0, "end word without a final character")

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

`default_nettype wire

[sim/tb_infix_to_postfix_converter.sv]
// Self-checking testbench for the infix to postfix converter: directed script, random formulas.
module tb_infix_to_postfix_converter
	import itp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// A hold-off this long lets the command queue and the input side fill up.
	localparam int HOLD_CYCLES = 300;
	// Longest stretch without any word moving on either side before giving up.
	localparam int WATCHDOG_LIMIT = 2000;
	// Quiet time after the last expected word.
	localparam int DRAIN_CYCLES = 20;
	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_PHASES = 4;
	// Words per random phase; with the script this makes about 370.
	localparam int PHASE_WORDS = 86;

	localparam logic [7:0] LETTER_A = "a";
	localparam logic [7:0] LETTER_Z = "z";

	localparam logic [7:0] OPERATORS [6] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		CH_CARET, CH_DOLLAR};
	// Noise draws half of its characters from the ones the converter treats specially.
	localparam logic [7:0] NOISE_PICKS [9] = '{CH_SPACE, CH_OPEN, CH_CLOSE, CH_PLUS,
		CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_DOLLAR};

	// Percent of cycles in which the sender idles and the receiver stalls, per phase.
	localparam int SEND_IDLE [RANDOM_PHASES] = '{0, 58, 0, 6};
	localparam int RECV_STALL [RANDOM_PHASES] = '{0, 0, 58, 6};

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		out_word_t  want;
	} script_row_t;

	localparam out_word_t NO_WORD = '0;

	// The opening rows have results that are obvious: plain operands at the extremes of
	// the character range, a bare end word, and the two unmatched parenthesis errors.
	// The longer formulas after them exercise every operator and the repeated pops,
	// and the last one closes a parenthesis that was never opened.
	localparam script_row_t SCRIPT [DIRECTED_ROWS] = '{
		'{"a",      1'b0, 1'b1, '{"a",   1'b1, 1'b0, 1'b0}},
		'{8'h00,    1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
		'{8'hFF,    1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
		'{CH_SPACE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
		'{CH_CLOSE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{CH_OPEN,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{CH_OPEN,  1'b0, 1'b0, NO_WORD},
		'{"a",      1'b0, 1'b0, NO_WORD},
		'{CH_PLUS,  1'b0, 1'b0, NO_WORD},
		'{"b",      1'b0, 1'b0, NO_WORD},
		'{CH_CLOSE, 1'b0, 1'b0, NO_WORD},
		'{CH_STAR,  1'b0, 1'b0, NO_WORD},
		'{"c",      1'b0, 1'b0, NO_WORD},
		'{CH_CARET, 1'b0, 1'b0, NO_WORD},
		'{"d",      1'b0, 1'b0, NO_WORD},
		'{CH_DOLLAR, 1'b0, 1'b0, NO_WORD},
		'{"e",      1'b0, 1'b0, NO_WORD},
		'{CH_MINUS, 1'b0, 1'b0, NO_WORD},
		'{"f",      1'b0, 1'b0, NO_WORD},
		'{CH_SLASH, 1'b0, 1'b0, NO_WORD},
		'{"g",      1'b1, 1'b0, NO_WORD},
		'{"x",      1'b0, 1'b0, NO_WORD},
		'{CH_PLUS,  1'b0, 1'b0, NO_WORD},
		'{"y",      1'b0, 1'b0, NO_WORD},
		'{CH_CLOSE, 1'b1, 1'b0, NO_WORD}
	};

	logic      clk;
	logic      arst_n = 1'b0;
	logic      sym_valid = 1'b0;
	logic      sym_ready;
	in_word_t  sym_word = '0;
	logic      post_valid;
	logic      post_ready = 1'b0;
	out_word_t post_word;

	// Sideband that travels with the offered word: whether its result is typed into
	// the script, and what that result is. Driven together with the payload.
	logic      row_typed = 1'b0;
	out_word_t row_want = '0;

	// Shadow copy of the converter's state, kept by the postfix predictor below.
	logic [7:0] op_stack [DEFAULT_STACK_DEPTH];
	int         op_count = 0;
	logic       error_seen = 1'b0;
	out_word_t  expected_words [$];

	logic [7:0] infix_text [$];
	int         items_sent = 0;
	int         fail_count = 0;
	int         idle_run = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_requests = 0;
	int         holds_served = 0;
	int         hold_left = 0;

	infix_to_postfix_converter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_ready  (sym_ready),
		.sym_word   (sym_word),
		.post_valid (post_valid),
		.post_ready (post_ready),
		.post_word  (post_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic is_arith_op(input logic [7:0] ch);
		return ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH ||
			ch == CH_CARET || ch == CH_DOLLAR;
	endfunction

	// Anything that is not one of the six operators ranks like an open parenthesis,
	// which is the only other thing that ever sits on the stack.
	function automatic logic [2:0] op_rank(input logic [7:0] ch);
		case (ch)
			CH_PLUS, CH_MINUS: return PREC_ADD;
			CH_STAR, CH_SLASH: return PREC_MUL;
			CH_CARET, CH_DOLLAR: return PREC_POW;
			default: return PREC_OPEN;
		endcase
	endfunction

	function automatic void emit_symbol(input logic [7:0] ch);
		expected_words.push_back('{out_symbol: ch, has_symbol: 1'b1,
			end_of_expression: 1'b0, error: 1'b0});
	endfunction

	// A push onto a full stack is lost and only leaves the sticky error behind.
	function automatic void push_operator(input logic [7:0] ch);
		if (op_count >= DEFAULT_STACK_DEPTH) begin
			error_seen = 1'b1;
		end else begin
			op_stack[op_count] = ch;
			op_count++;
		end
	endfunction

	// Runs one input word through the shunting-yard rules, appends the postfix words it
	// causes to the expected list and returns how many it appended.
	function automatic int shunt_symbol(input in_word_t w);
		int         first;
		logic [7:0] top;
		logic       matched;
		out_word_t  closing;
		first = expected_words.size();
		matched = 1'b0;
		if (w.symbol == CH_OPEN) begin
			push_operator(w.symbol);
		end else if (w.symbol == CH_CLOSE) begin
			// Pop down to the matching open parenthesis, or to the bottom if there is none.
			while (op_count > 0 && !matched) begin
				op_count--;
				top = op_stack[op_count];
				if (top == CH_OPEN) begin
					matched = 1'b1;
				end else begin
					emit_symbol(top);
				end
			end
			if (!matched) begin
				error_seen = 1'b1;
			end
		end else if (is_arith_op(w.symbol)) begin
			// Equal rank pops too, so every operator binds to the left.
			while (op_count > 0 && op_rank(op_stack[op_count - 1]) >= op_rank(w.symbol)) begin
				op_count--;
				emit_symbol(op_stack[op_count]);
			end
			push_operator(w.symbol);
		end else if (w.symbol != CH_SPACE) begin
			emit_symbol(w.symbol);
		end
		if (w.is_last) begin
			// Flush: operators go out, a leftover open parenthesis only raises the error.
			while (op_count > 0) begin
				op_count--;
				top = op_stack[op_count];
				if (top == CH_OPEN) begin
					error_seen = 1'b1;
				end else begin
					emit_symbol(top);
				end
			end
			if (expected_words.size() == first) begin
				expected_words.push_back('0);
			end
			closing = expected_words.pop_back();
			closing.end_of_expression = 1'b1;
			closing.error = error_seen;
			expected_words.push_back(closing);
			error_seen = 1'b0;
		end
		return expected_words.size() - first;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Every accepted word is predicted here, and every accepted postfix word is checked
	// against the oldest expectation. All sampling happens at the rising edge, before the
	// nonblocking updates of that edge land. The watchdog shares the same edge.
	always @(posedge clk) begin
		int        produced;
		out_word_t want;
		if (!arst_n) begin
			idle_run = 0;
		end else begin
			if (sym_valid && sym_ready) begin
				produced = shunt_symbol(sym_word);
				if (row_typed) begin
					repeat (produced) expected_words.delete(expected_words.size() - 1);
					expected_words.push_back(row_want);
				end
			end
			if (post_valid && post_ready) begin
				if (expected_words.size() == 0) begin
					note_failure($sformatf("unexpected postfix word: sym=%h has=%b end=%b err=%b",
						post_word.out_symbol, post_word.has_symbol,
						post_word.end_of_expression, post_word.error));
				end else begin
					want = expected_words.pop_front();
					if (post_word.out_symbol !== want.out_symbol ||
							post_word.has_symbol !== want.has_symbol ||
							post_word.end_of_expression !== want.end_of_expression ||
							post_word.error !== want.error) begin
						note_failure($sformatf(
							"postfix mismatch: expected sym=%h has=%b end=%b err=%b, got sym=%h has=%b end=%b err=%b",
							want.out_symbol, want.has_symbol, want.end_of_expression,
							want.error, post_word.out_symbol, post_word.has_symbol,
							post_word.end_of_expression, post_word.error));
					end
				end
			end
			if ((sym_valid && sym_ready) || (post_valid && post_ready)) begin
				idle_run = 0;
			end else begin
				idle_run++;
			end
			if (idle_run >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver. A pending hold request turns into a long stretch with ready low;
	// otherwise ready follows the stall rate of the current phase.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			post_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			post_ready <= 1'b0;
		end else begin
			post_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Offers one word and returns at the edge where it was taken. Idle cycles come first,
	// so valid is never dropped while a word is on offer.
	task automatic offer_symbol(input logic [7:0] ch, input logic last, input logic typed,
			input out_word_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sym_valid <= 1'b0;
			@(posedge clk);
		end
		sym_valid <= 1'b1;
		sym_word <= '{symbol: ch, is_last: last};
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (!sym_ready);
		items_sent++;
	endtask

	// Stops offering and waits until every predicted postfix word has come out.
	task automatic wait_for_drain();
		sym_valid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	function automatic logic [7:0] pick_operand();
		logic [7:0] ch;
		if ($urandom_range(0, 99) < 75) begin
			return 8'($urandom_range(LETTER_A, LETTER_Z));
		end
		// Any other byte that the converter passes straight through.
		do begin
			ch = 8'($urandom_range(0, 255));
		end while (ch == CH_SPACE || ch == CH_OPEN || ch == CH_CLOSE || is_arith_op(ch));
		return ch;
	endfunction

	function automatic void add_token(input logic [7:0] ch);
		if ($urandom_range(0, 99) < 10) begin
			infix_text.push_back(CH_SPACE);
		end
		infix_text.push_back(ch);
	endfunction

	// A well-formed formula: operands joined by random operators, with parentheses
	// opened and closed at random up to three deep, all of them closed at the end.
	function automatic void compose_formula();
		int depth;
		int terms;
		int t;
		depth = 0;
		terms = $urandom_range(1, 6);
		for (t = 0; t < terms; t++) begin
			while (depth < 3 && $urandom_range(0, 99) < 25) begin
				add_token(CH_OPEN);
				depth++;
			end
			add_token(pick_operand());
			while (depth > 0 && $urandom_range(0, 99) < 35) begin
				add_token(CH_CLOSE);
				depth--;
			end
			if (t != terms - 1) begin
				add_token(OPERATORS[$urandom_range(0, 5)]);
			end
		end
		while (depth > 0) begin
			add_token(CH_CLOSE);
			depth--;
		end
	endfunction

	// Builds the next random expression. Most are well formed; the rest are formulas
	// with a stray or missing character, raw noise, single characters, and deep nests
	// of "(operand operator" that leave two entries per level and can run past the stack.
	function automatic void build_expression(input logic deep);
		int style;
		int levels;
		int pos;
		infix_text.delete();
		style = deep ? 100 : $urandom_range(0, 99);
		if (style < 70) begin
			compose_formula();
		end else if (style < 82) begin
			compose_formula();
			pos = $urandom_range(0, infix_text.size() - 1);
			case ($urandom_range(0, 2))
				0: infix_text.insert(pos, CH_CLOSE);
				1: infix_text.insert(pos, CH_OPEN);
				default: begin
					if (infix_text.size() > 1) begin
						infix_text.delete(pos);
					end
				end
			endcase
		end else if (style < 92) begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 1) == 0) begin
					infix_text.push_back(8'($urandom_range(0, 255)));
				end else begin
					infix_text.push_back(NOISE_PICKS[$urandom_range(0, 8)]);
				end
			end
		end else if (style < 96) begin
			infix_text.push_back(8'($urandom_range(0, 255)));
		end else begin
			levels = deep ? 20 : $urandom_range(12, 22);
			repeat (levels) begin
				add_token(CH_OPEN);
				add_token(pick_operand());
				add_token(OPERATORS[$urandom_range(0, 5)]);
			end
			add_token(pick_operand());
			repeat ($urandom_range(0, levels)) add_token(CH_CLOSE);
		end
	endfunction

	task automatic send_expression();
		int idx;
		for (idx = 0; idx < infix_text.size(); idx++) begin
			offer_symbol(infix_text[idx], idx == infix_text.size() - 1, 1'b0, NO_WORD);
		end
	endtask

	initial begin
		int row;
		int phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			offer_symbol(SCRIPT[row].ch, SCRIPT[row].last, SCRIPT[row].typed, SCRIPT[row].want);
		end

		// Each phase starts from an empty converter and opens with a nest deep enough
		// to overflow the stack. In the first phase the receiver also holds off for a
		// long time while words keep coming, so the input side backs up.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_drain();
			send_idle_pct = SEND_IDLE[phase];
			recv_stall_pct = RECV_STALL[phase];
			if (phase == 0) begin
				hold_requests++;
			end
			build_expression(1'b1);
			send_expression();
			while (items_sent < DIRECTED_ROWS + (phase + 1) * PHASE_WORDS) begin
				build_expression(1'b0);
				send_expression();
			end
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
